>>> src/nsps_pkg.sv
// shared types and constants for the nearest skeleton point search
`timescale 1ns / 1ps

package nsps_pkg;

	// default sizes of the point store
	localparam int DEF_MAX_POINTS   = 1024;
	localparam int DEF_MAX_SEGMENTS = 256;
	localparam int DEF_COORD_BITS   = 21;

	// fixed widths of the item fields
	localparam int KIND_W    = 2;
	localparam int LIMIT_W   = 46;
	localparam int SEG_OUT_W = 8;
	localparam int IDX_OUT_W = 10;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} nsps_state_t;

endpackage

>>> src/nearest_skeleton_point_search.sv
// top level: point store with brute-force nearest-point query
`timescale 1ns / 1ps
// clear and append items: result strobe in the cycle after the item is accepted, one item per cycle while no query runs
// query items: the result is set by one ram read per point,
// a four-stage distance pipeline and the result register
// busy is high for the whole query; one item at a time, receiver cannot stall
// arst_n empties the store and returns to idle; ram contents are not cleared

module nearest_skeleton_point_search #(
	parameter int MAX_POINTS   = nsps_pkg::DEF_MAX_POINTS,
	parameter int MAX_SEGMENTS = nsps_pkg::DEF_MAX_SEGMENTS,
	parameter int COORD_BITS   = nsps_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [nsps_pkg::KIND_W-1:0]   kind,
	input  logic                          new_segment,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	input  logic signed [COORD_BITS-1:0]  coord_z,
	input  logic [nsps_pkg::LIMIT_W-1:0]  limit,
	output logic                          done,
	output logic                          found,
	output logic                          full_error,
	output logic [nsps_pkg::SEG_OUT_W-1:0] segment_index,
	output logic [nsps_pkg::IDX_OUT_W-1:0] point_index,
	output logic [nsps_pkg::LIMIT_W-1:0]  dist_sq
);

	import nsps_pkg::*;

	localparam int AW      = $clog2(MAX_POINTS);
	localparam int PW      = $clog2(MAX_POINTS + 1);
	localparam int SW      = $clog2(MAX_SEGMENTS + 1);
	localparam int CB      = COORD_BITS;
	localparam int MAG_W   = CB + 1;
	localparam int SUM_W   = 2 * CB + 2;
	localparam int CMP_W   = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
	localparam int ENTRY_W = 3 * CB + SEG_OUT_W + IDX_OUT_W;

	nsps_state_t state_q, state_d;

	// store counters
	logic [PW-1:0] points_q;
	logic [SW-1:0] segments_q;
	logic [PW-1:0] seg_len_q;

	// scan control
	logic [PW-1:0] rd_cnt_q;
	logic          issue;
	logic          scan_end;
	logic          accept;
	logic          v_s1, v_s2, v_s3, v_s4;

	// query operands and running best
	logic signed [CB-1:0] qx_q, qy_q, qz_q;
	logic [CMP_W-1:0]     best_q;
	logic                 best_found_q;
	logic [SEG_OUT_W-1:0] best_seg_q;
	logic [IDX_OUT_W-1:0] best_idx_q;

	// result registers
	logic                 done_q;
	logic                 found_q;
	logic                 full_q;
	logic [SEG_OUT_W-1:0] seg_out_q;
	logic [IDX_OUT_W-1:0] idx_out_q;
	logic [LIMIT_W-1:0]   dist_out_q;

	// append decode
	logic                 start_new;
	logic                 is_full;
	logic                 do_write;
	logic [SEG_OUT_W-1:0] wr_seg;
	logic [IDX_OUT_W-1:0] wr_idx;
	logic [ENTRY_W-1:0]   wr_entry;

	// ram read side
	logic [ENTRY_W-1:0]   rd_entry;
	logic signed [CB-1:0] rd_x, rd_y, rd_z;
	logic [SEG_OUT_W-1:0] rd_seg;
	logic [IDX_OUT_W-1:0] rd_idx;

	// distance pipeline
	logic signed [CB:0]   dx, dy, dz;
	logic [MAG_W-1:0]     mag_x_s2, mag_y_s2, mag_z_s2;
	logic [SEG_OUT_W-1:0] seg_s2, seg_s3, seg_s4;
	logic [IDX_OUT_W-1:0] idx_s2, idx_s3, idx_s4;
	logic [SUM_W-1:0]     sq_x_s3, sq_y_s3, sq_z_s3;
	logic [SUM_W-1:0]     sum_s4;
	logic                 better;

	assign accept = start && (state_q == ST_IDLE);

	// append decode
	always_comb begin
		start_new = new_segment || (segments_q == '0);
		is_full   = (points_q == PW'(MAX_POINTS)) ||
			(start_new && (segments_q == SW'(MAX_SEGMENTS)));
		do_write  = accept && (kind == KIND_APPEND) && !is_full;
		wr_seg    = start_new ? SEG_OUT_W'(segments_q) : SEG_OUT_W'(segments_q - 1'b1);
		wr_idx    = start_new ? '0 : IDX_OUT_W'(seg_len_q);
		wr_entry  = {wr_seg, wr_idx, coord_z, coord_y, coord_x};
	end

	nsps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_point_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (points_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rd_entry)
	);

	assign {rd_seg, rd_idx, rd_z, rd_y, rd_x} = rd_entry;

	// next state and scan control
	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		scan_end = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = (rd_cnt_q < points_q);
				if (!issue && !v_s1 && !v_s2 && !v_s3 && !v_s4) begin
					scan_end = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, counters and strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			points_q   <= '0;
			segments_q <= '0;
			seg_len_q  <= '0;
			rd_cnt_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			done_q  <= (accept && (kind != KIND_QUERY)) || scan_end;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (accept && (kind == KIND_CLEAR)) begin
				points_q   <= '0;
				segments_q <= '0;
				seg_len_q  <= '0;
			end else if (do_write) begin
				points_q <= points_q + 1'b1;
				if (start_new) begin
					segments_q <= segments_q + 1'b1;
					seg_len_q  <= PW'(1);
				end else begin
					seg_len_q <= seg_len_q + 1'b1;
				end
			end
		end
	end

	// distance pipeline: abs difference, square, sum
	always_comb begin
		dx = {rd_x[CB-1], rd_x} - {qx_q[CB-1], qx_q};
		dy = {rd_y[CB-1], rd_y} - {qy_q[CB-1], qy_q};
		dz = {rd_z[CB-1], rd_z} - {qz_q[CB-1], qz_q};
	end

	always_ff @(posedge clk) begin
		mag_x_s2 <= dx[CB] ? MAG_W'(~dx + 1'b1) : MAG_W'(dx);
		mag_y_s2 <= dy[CB] ? MAG_W'(~dy + 1'b1) : MAG_W'(dy);
		mag_z_s2 <= dz[CB] ? MAG_W'(~dz + 1'b1) : MAG_W'(dz);
		seg_s2   <= rd_seg;
		idx_s2   <= rd_idx;
		sq_x_s3  <= SUM_W'(mag_x_s2) * SUM_W'(mag_x_s2);
		sq_y_s3  <= SUM_W'(mag_y_s2) * SUM_W'(mag_y_s2);
		sq_z_s3  <= SUM_W'(mag_z_s2) * SUM_W'(mag_z_s2);
		seg_s3   <= seg_s2;
		idx_s3   <= idx_s2;
		sum_s4   <= sq_x_s3 + sq_y_s3 + sq_z_s3;
		seg_s4   <= seg_s3;
		idx_s4   <= idx_s3;
	end

	assign better = v_s4 && (CMP_W'(sum_s4) < best_q);

	// query operands and running minimum
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_QUERY)) begin
			qx_q         <= coord_x;
			qy_q         <= coord_y;
			qz_q         <= coord_z;
			best_q       <= CMP_W'(limit);
			best_found_q <= 1'b0;
			best_seg_q   <= '0;
			best_idx_q   <= '0;
		end else if (better) begin
			best_q       <= CMP_W'(sum_s4);
			best_found_q <= 1'b1;
			best_seg_q   <= seg_s4;
			best_idx_q   <= idx_s4;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (scan_end) begin
			found_q    <= best_found_q;
			full_q     <= 1'b0;
			seg_out_q  <= best_seg_q;
			idx_out_q  <= best_idx_q;
			dist_out_q <= best_found_q ? best_q[LIMIT_W-1:0] : '0;
		end else if (accept) begin
			found_q    <= 1'b0;
			full_q     <= (kind == KIND_APPEND) && is_full;
			seg_out_q  <= '0;
			idx_out_q  <= '0;
			dist_out_q <= '0;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign found         = found_q;
	assign full_error    = full_q;
	assign segment_index = seg_out_q;
	assign point_index   = idx_out_q;
	assign dist_sq       = dist_out_q;

endmodule

>>> src/nsps_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module nsps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
